FILE: design/tpal_pkg.sv
// Package: shared types and constants for the three-axis PID acceleration limiter.
package tpal_pkg;
	localparam int unsigned NUM_AXES = 3;
	localparam logic [2:0] REG_KP_XY = 3'd0;
	localparam logic [2:0] REG_KP_Z  = 3'd1;
	localparam logic [2:0] REG_KV_XY = 3'd2;
	localparam logic [2:0] REG_KV_Z  = 3'd3;
	localparam logic [2:0] REG_KI_XY = 3'd4;
	localparam logic [2:0] REG_KI_Z  = 3'd5;
	localparam logic [2:0] REG_MAX_INT = 3'd6;
	localparam logic [2:0] REG_MAX_ACC = 3'd7;

	typedef struct packed {
		logic [15:0] kp_xy;
		logic [15:0] kp_z;
		logic [15:0] kv_xy;
		logic [15:0] kv_z;
		logic [15:0] ki_xy;
		logic [15:0] ki_z;
		logic [30:0] int_limit;
		logic [30:0] max_feedback_acc;
	} cfg_t;

	// controller -> datapath
	typedef enum logic [3:0] {
		OP_NONE  = 4'd0,
		OP_LOAD  = 4'd1,
		OP_INTEG = 4'd2,
		OP_MAC   = 4'd3,
		OP_SHIFT = 4'd4,
		OP_SQ    = 4'd5,
		OP_SQRT  = 4'd6,
		OP_SCALE = 4'd7,
		OP_DIV   = 4'd8,
		OP_FINAL = 4'd9
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		logic [2:0] term;
	} cmd_t;

	typedef struct packed {
		logic need_shift;
		logic limited;
	} sts_t;
endpackage

FILE: design/tpal_ctrl.sv
// Sequencer: walks one control step through the shared datapath.
module tpal_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tpal_pkg::sts_t  sts,
	output tpal_pkg::cmd_t  cmd,
	output logic            done
);
	import tpal_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_INTEG = 10'b0000000010,
		S_MAC   = 10'b0000000100,
		S_SHIFT = 10'b0000001000,
		S_SQ    = 10'b0000010000,
		S_SQRT  = 10'b0000100000,
		S_SCALE = 10'b0001000000,
		S_DIV   = 10'b0010000000,
		S_FINAL = 10'b0100000000,
		S_LOAD  = 10'b1000000000
	} state_t;

	state_t     state_q;
	logic [1:0] axis_q;
	logic [2:0] term_q;
	logic [5:0] cnt_q;

	always_comb begin
		cmd.axis = axis_q;
		cmd.term = term_q;
		done = 1'b0;
		case (state_q)
			S_LOAD:  cmd.op = OP_LOAD;
			S_INTEG: cmd.op = OP_INTEG;
			S_MAC:   cmd.op = OP_MAC;
			S_SHIFT: cmd.op = OP_SHIFT;
			S_SQ:    cmd.op = OP_SQ;
			S_SQRT:  cmd.op = OP_SQRT;
			S_SCALE: cmd.op = OP_SCALE;
			S_DIV:   cmd.op = OP_DIV;
			S_FINAL: begin
				cmd.op = OP_FINAL;
				done = 1'b1;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= '0;
			term_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_LOAD;
				S_LOAD: begin
					state_q <= S_INTEG;
					axis_q <= '0;
				end
				S_INTEG: begin
					if (axis_q == 2'd2) begin
						axis_q <= '0;
						term_q <= '0;
						state_q <= S_MAC;
					end else axis_q <= axis_q + 2'd1;
				end
				S_MAC: begin
					// term 0..2 multiply, 3 rounds into a[axis]
					if (term_q == 3'd3) begin
						term_q <= '0;
						if (axis_q == 2'd2) begin
							axis_q <= '0;
							state_q <= S_SHIFT;
						end else axis_q <= axis_q + 2'd1;
					end else term_q <= term_q + 3'd1;
				end
				S_SHIFT: if (!sts.need_shift) begin
					state_q <= S_SQ;
					term_q <= '0;
				end
				S_SQ: begin
					// 0..2 square, 3 compare
					if (term_q == 3'd3) begin
						term_q <= '0;
						if (sts.limited) begin
							state_q <= S_SQRT;
							cnt_q <= '0;
						end else state_q <= S_FINAL;
					end else term_q <= term_q + 3'd1;
				end
				S_SQRT: begin
					if (cnt_q == 6'd31) begin
						state_q <= S_SCALE;
						axis_q <= '0;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				S_SCALE: begin
					state_q <= S_DIV;
					cnt_q <= '0;
				end
				S_DIV: begin
					// one quotient bit per cycle, 62 numerator bits
					if (cnt_q == 6'd61) begin
						if (axis_q == 2'd2) state_q <= S_FINAL;
						else begin
							axis_q <= axis_q + 2'd1;
							state_q <= S_SCALE;
						end
					end
					cnt_q <= cnt_q + 6'd1;
				end
				S_FINAL: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/tpal_dp.sv
// Datapath: integral update, shared multiplier, root and divider units.
module tpal_dp #(
	parameter int unsigned HOLDOFF_STEPS = 300
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tpal_pkg::cmd_t  cmd,
	input  tpal_pkg::cfg_t  cfg,
	input  logic            int_clr,
	input  logic [192:0]    in_word,
	output tpal_pkg::sts_t  sts,
	output logic [96:0]     out_word
);
	import tpal_pkg::*;

	logic signed [31:0] pe_q [3];
	logic signed [31:0] ve_q [3];
	logic signed [31:0] integ_q [3];
	logic signed [41:0] a_q [3];
	logic        [40:0] b_q [3];
	logic               neg_q [3];
	logic        [8:0]  step_q;
	logic signed [49:0] sum_q;
	logic        [63:0] n2_q;
	logic               lim_q;
	// sqrt
	logic        [63:0] rx_q;
	logic        [63:0] rr_q;
	logic        [63:0] rb_q;
	// divider: numerator b*lim (62 bits)
	logic        [61:0] num_q;
	logic        [62:0] rem_q;
	logic        [61:0] quo_q;
	logic        [31:0] res_q [3];

	logic signed [16:0] gain;
	logic signed [31:0] opnd;
	logic signed [48:0] prod;
	logic signed [32:0] inc;
	logic signed [33:0] s_int;
	logic signed [33:0] mi;
	logic        [62:0] rem_sh;
	logic        [63:0] rtry;
	logic signed [50:0] nsum;
	logic signed [50:0] wr;
	logic signed [33:0] neg_pe;
	logic        [33:0] mag_pe;
	logic        [33:0] q100;
	logic        [63:0] sq;
	logic               any_big;
	logic               over_lim;
	logic signed [42:0] sat_in;
	logic [1:0] ax;

	assign ax = cmd.axis;
	assign mi = {3'b000, cfg.int_limit};

	// round(e/100), ties away: magnitude (|e|+50)*ceil(2^38/100) >> 38 is exact for 33b
	assign mag_pe = pe_q[ax][31] ? 34'(-{{2{pe_q[ax][31]}}, pe_q[ax]}) : 34'(pe_q[ax]);
	always_comb begin
		logic [73:0] t;
		t = 74'((mag_pe + 34'd50) * 40'd2748779070);
		q100 = 34'(t >> 38);
	end
	assign neg_pe = -$signed(q100);
	assign inc = pe_q[ax][31] ? 33'(neg_pe) : 33'($signed(q100));
	assign s_int = 34'(integ_q[ax]) + 34'(inc);

	always_comb begin
		case (cmd.term)
			3'd0: begin
				gain = (ax == 2'd2) ? {1'b0, cfg.kp_z} : {1'b0, cfg.kp_xy};
				opnd = pe_q[ax];
			end
			3'd1: begin
				gain = (ax == 2'd2) ? {1'b0, cfg.kv_z} : {1'b0, cfg.kv_xy};
				opnd = ve_q[ax];
			end
			default: begin
				gain = (ax == 2'd2) ? {1'b0, cfg.ki_z} : {1'b0, cfg.ki_xy};
				opnd = integ_q[ax];
			end
		endcase
	end
	assign prod = gain * opnd;
	assign nsum = -51'(sum_q);
	assign wr = nsum + 51'sd128;

	assign any_big = (b_q[0][40:31] != 0) || (b_q[1][40:31] != 0) || (b_q[2][40:31] != 0);
	assign sq = b_q[cmd.term[1:0]][31:0] * b_q[cmd.term[1:0]][31:0];
	assign over_lim = n2_q > 64'(cfg.max_feedback_acc) * 64'(cfg.max_feedback_acc);
	assign rtry = rr_q + rb_q;
	assign rem_sh = {rem_q[61:0], num_q[61]};
	assign sts.need_shift = any_big;
	assign sts.limited = lim_q || over_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			for (int i = 0; i < 3; i++) integ_q[i] <= '0;
		end else if (int_clr) begin
			for (int i = 0; i < 3; i++) integ_q[i] <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (in_word[192] || (cfg.int_limit != 0 && step_q < 9'(HOLDOFF_STEPS)))
						for (int i = 0; i < 3; i++) integ_q[i] <= '0;
				end
				OP_INTEG: begin
					if (cfg.int_limit != 0 && step_q >= 9'(HOLDOFF_STEPS)) begin
						if (s_int > mi) integ_q[ax] <= 32'(mi);
						else if (s_int < -mi) integ_q[ax] <= 32'(-mi);
						else integ_q[ax] <= 32'(s_int);
					end
				end
				OP_FINAL: if (step_q != 9'd511) step_q <= step_q + 9'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				lim_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					pe_q[i] <= in_word[32*i +: 32];
					ve_q[i] <= in_word[96+32*i +: 32];
				end
			end
			OP_MAC: begin
				if (cmd.term == 3'd0) sum_q <= 50'(prod);
				else if (cmd.term != 3'd3) sum_q <= sum_q + 50'(prod);
				else begin
					a_q[ax] <= 42'(wr >>> 8);
					neg_q[ax] <= wr[50];
					b_q[ax] <= wr[50] ? 41'(-(wr >>> 8)) : 41'(wr >>> 8);
				end
			end
			OP_SHIFT: begin
				if (any_big) begin
					lim_q <= 1'b1;
					for (int i = 0; i < 3; i++) b_q[i] <= b_q[i] >> 1;
				end
			end
			OP_SQ: begin
				if (cmd.term == 3'd0) n2_q <= sq;
				else if (cmd.term != 3'd3) n2_q <= n2_q + sq;
				else begin
					lim_q <= lim_q || over_lim;
					rx_q <= n2_q;
					rr_q <= '0;
					rb_q <= 64'h4000_0000_0000_0000;
				end
			end
			OP_SQRT: begin
				if (rx_q >= rtry) begin
					rx_q <= rx_q - rtry;
					rr_q <= (rr_q >> 1) + rb_q;
				end else rr_q <= rr_q >> 1;
				rb_q <= rb_q >> 2;
			end
			OP_SCALE: begin
				num_q <= b_q[ax][30:0] * cfg.max_feedback_acc;
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_DIV: begin
				num_q <= num_q << 1;
				if (rem_sh >= rr_q[62:0]) begin
					rem_q <= rem_sh - rr_q[62:0];
					quo_q <= {quo_q[60:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[60:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// final result per axis; q fits 32 bits once limited
	logic [61:0] qfin;
	assign qfin = (rr_q == 0) ? 62'd0 :
		((rem_sh >= rr_q[62:0]) ? {quo_q[60:0], 1'b1} : {quo_q[60:0], 1'b0});
	always_ff @(posedge clk) begin
		if (cmd.op == OP_DIV) res_q[ax] <= neg_q[ax] ? 32'(-qfin) : 32'(qfin);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sat_in = 43'(a_q[i]);
			if (lim_q) out_word[32*i +: 32] = res_q[i];
			else if (sat_in > 43'sd2147483647) out_word[32*i +: 32] = 32'h7FFF_FFFF;
			else if (sat_in < -43'sd2147483648) out_word[32*i +: 32] = 32'h8000_0000;
			else out_word[32*i +: 32] = 32'(a_q[i]);
		end
		out_word[96] = lim_q;
	end
endmodule

FILE: design/three_axis_pid_accel_limiter_unit.sv
// Top level: stream ports, APB register file, controller and datapath.
// Before the feedback norm is checked, the components are halved until they lie below 2^31;
// any halving marks the step as limited, and a step beyond its limit is scaled by a 32-step
// square root and three 62-step restoring divisions in the shared datapath. One step is
// worked at a time; the result sits in an output register, and the next word is taken
// once it is accepted.
module three_axis_pid_accel_limiter_unit #(
	parameter int unsigned HOLDOFF_STEPS = 300
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // pos_err_x, y, z, vel_err_x, y, z
	input  logic         s_tuser,  // clear_integral
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // acc_x, acc_y, acc_z
	output logic         m_tuser,  // norm_limited
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import tpal_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic       busy_q;
	logic       done;
	logic       int_clr;
	logic [192:0] in_q;
	logic [96:0]  res;
	logic       wr_en;
	logic [2:0] ra;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign ra = paddr[4:2];
	assign s_tready = !busy_q && !m_tvalid;
	assign int_clr = wr_en && ra == REG_MAX_INT &&
		((cfg_q.int_limit == 0) != (pwdata[30:0] == 0));

	always_comb begin
		case (ra)
			REG_KP_XY: prdata = {16'd0, cfg_q.kp_xy};
			REG_KP_Z:  prdata = {16'd0, cfg_q.kp_z};
			REG_KV_XY: prdata = {16'd0, cfg_q.kv_xy};
			REG_KV_Z:  prdata = {16'd0, cfg_q.kv_z};
			REG_KI_XY: prdata = {16'd0, cfg_q.ki_xy};
			REG_KI_Z:  prdata = {16'd0, cfg_q.ki_z};
			REG_MAX_INT: prdata = {1'b0, cfg_q.int_limit};
			REG_MAX_ACC: prdata = {1'b0, cfg_q.max_feedback_acc};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_xy <= 16'd2048;
			cfg_q.kp_z <= 16'd2560;
			cfg_q.kv_xy <= 16'd384;
			cfg_q.kv_z <= 16'd845;
			cfg_q.ki_xy <= '0;
			cfg_q.ki_z <= '0;
			cfg_q.int_limit <= '0;
			cfg_q.max_feedback_acc <= 31'd589824;
			busy_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (wr_en) begin
				case (ra)
					REG_KP_XY: cfg_q.kp_xy <= pwdata[15:0];
					REG_KP_Z:  cfg_q.kp_z <= pwdata[15:0];
					REG_KV_XY: cfg_q.kv_xy <= pwdata[15:0];
					REG_KV_Z:  cfg_q.kv_z <= pwdata[15:0];
					REG_KI_XY: cfg_q.ki_xy <= pwdata[15:0];
					REG_KI_Z:  cfg_q.ki_z <= pwdata[15:0];
					REG_MAX_INT: cfg_q.int_limit <= pwdata[30:0];
					REG_MAX_ACC: cfg_q.max_feedback_acc <= pwdata[30:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) busy_q <= 1'b1;
			else if (done) busy_q <= 1'b0;
			if (done) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) in_q <= {s_tuser, s_tdata};
		if (done) begin
			m_tdata <= res[95:0];
			m_tuser <= res[96];
		end
	end

	tpal_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(s_tvalid && s_tready),
		.sts(sts), .cmd(cmd), .done(done)
	);

	tpal_dp #(.HOLDOFF_STEPS(HOLDOFF_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg(cfg_q), .int_clr(int_clr),
		.in_word(in_q), .sts(sts), .out_word(res)
	);
endmodule
